// File: rtl/core/she_pkg.sv
// Shared types, character codes and entity string tables for the snippet HTML escaper.
// Used by she_front, she_tokq, she_back and snippet_html_escaper. No dependencies.
`default_nettype none

package she_pkg;

	// token kinds: one literal byte, or one fixed string
	localparam logic [3:0] TK_LIT  = 4'd0;
	localparam logic [3:0] TK_QUOT = 4'd1;
	localparam logic [3:0] TK_APOS = 4'd2;
	localparam logic [3:0] TK_GT   = 4'd3;
	localparam logic [3:0] TK_AMP  = 4'd4;
	localparam logic [3:0] TK_LT   = 4'd5;
	localparam logic [3:0] TK_B    = 4'd6;	// tags follow in match order
	localparam logic [3:0] TK_BC   = 4'd7;
	localparam logic [3:0] TK_BR   = 4'd8;
	localparam logic [3:0] TK_WBR  = 4'd9;

	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_QUOT   = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] lit;
		logic       last;	// last result of this transaction
		logic       done;	// last result of the string
	} tok_t;

	typedef struct packed {
		logic       hit;
		logic       pend;
		logic [1:0] k;
	} tag_res_t;

	function automatic logic [2:0] str_len(input logic [3:0] kind);
		logic [2:0] len;
		case (kind)
			TK_QUOT: len = 3'd6;
			TK_APOS: len = 3'd5;
			TK_GT:   len = 3'd4;
			TK_AMP:  len = 3'd5;
			TK_LT:   len = 3'd4;
			TK_B:    len = 3'd3;
			TK_BC:   len = 3'd4;
			TK_BR:   len = 3'd4;
			TK_WBR:  len = 3'd5;
			default: len = 3'd1;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] str_char(input logic [3:0] kind, input logic [2:0] idx);
		logic [47:0] s;
		logic [2:0]  sh;
		case (kind)
			TK_QUOT: s = "&quot;";
			TK_APOS: s = {8'h00, "&#39;"};
			TK_GT:   s = {16'h0000, "&gt;"};
			TK_AMP:  s = {8'h00, "&amp;"};
			TK_LT:   s = {16'h0000, "&lt;"};
			TK_B:    s = {24'h000000, "<b>"};
			TK_BC:   s = {16'h0000, "</b>"};
			TK_BR:   s = {16'h0000, "<br>"};
			TK_WBR:  s = {8'h00, "<wbr>"};
			default: s = 48'h0;
		endcase
		sh = str_len(kind) - 3'd1 - idx;
		return s[{sh, 3'b000} +: 8];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/she_front.sv
// Front end: accepts bytes, keeps the lookahead window, matches tags and
// emits one token per cycle while tok_stall is low. Depends on she_pkg.
`default_nettype none

module she_front
	import she_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_string,
	output logic            tok_valid,
	output tok_t            tok,
	input  wire logic       tok_stall
);

	logic [4:0][7:0] hold_q;
	logic [2:0]      n_q;
	logic [2:0]      pos_q;
	logic            busy_q;
	logic            flush_q;
	logic            eos_q;
	logic            bold_q;

	function automatic logic [4:0][7:0] win(input logic [4:0][7:0] b, input logic [2:0] p);
		logic [4:0][7:0] w;
		logic [3:0]      ix;
		for (int i = 0; i < 5; i++) begin
			ix = {1'b0, p} + 4'(i);
			w[i] = (ix < 4'd5) ? b[ix[2:0]] : 8'h00;
		end
		return w;
	endfunction

	function automatic tag_res_t tag_eval(input logic [4:0][7:0] w, input logic [2:0] rem,
			input logic eos, input logic bold);
		tag_res_t   r;
		logic       pre;
		logic       skip;
		logic [2:0] len;
		logic [3:0] kd;
		r = '0;
		for (int k = 0; k < 4; k++) begin
			kd   = TK_B + 4'(k);
			len  = str_len(kd);
			skip = (k == 0 && bold) || (k == 1 && !bold);
			pre  = 1'b1;
			for (int i = 0; i < 5; i++) begin
				if (3'(i) < len && 3'(i) < rem && w[i] != str_char(kd, 3'(i)))
					pre = 1'b0;
			end
			if (!r.hit && !r.pend && !skip && pre) begin
				if (rem >= len) begin
					r.hit = 1'b1;
					r.k   = 2'(k);
				end else if (!eos) begin
					r.pend = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic logic must_hold(input logic [4:0][7:0] w, input logic [2:0] rem,
			input logic eos, input logic bold);
		tag_res_t r;
		r = tag_eval(w, rem, eos, bold);
		return (w[0] == CH_AMP && rem == 3'd1 && !eos) || (w[0] == CH_LT && r.pend);
	endfunction

	logic [4:0][7:0] w0, w1, base_buf, next_buf;
	logic [2:0]      rem0, rem1, adv, p1, base_n;
	tag_res_t        tr0;
	logic            hold0, hold1, in_rng1, fin_step, flush_need, bold_nx;
	logic            progress, fin, in_acc;
	logic [7:0]      c;
	tok_t            tk;

	always_comb begin
		w0    = win(hold_q, pos_q);
		rem0  = n_q - pos_q;
		tr0   = tag_eval(w0, rem0, eos_q, bold_q);
		hold0 = must_hold(w0, rem0, eos_q, bold_q);
		c     = w0[0];

		tk      = '0;
		adv     = 3'd1;
		bold_nx = bold_q;
		if (c == CH_AMP) begin
			if (rem0 >= 3'd2 && w0[1] == CH_LBRACE) begin
				tk.kind = TK_AMP;
			end else begin
				tk.kind = TK_LIT;
				tk.lit  = CH_AMP;
			end
		end else if (c == CH_LT) begin
			if (tr0.hit) begin
				tk.kind = TK_B + {2'b00, tr0.k};
				adv     = str_len(tk.kind);
				if (tr0.k == 2'd0)
					bold_nx = 1'b1;
				else if (tr0.k == 2'd1)
					bold_nx = 1'b0;
			end else begin
				tk.kind = TK_LT;
			end
		end else if (c == CH_QUOT) begin
			tk.kind = TK_QUOT;
		end else if (c == CH_APOS) begin
			tk.kind = TK_APOS;
		end else if (c == CH_GT) begin
			tk.kind = TK_GT;
		end else if (c >= CH_TAB && c <= CH_CR) begin
			tk.kind = TK_LIT;
			tk.lit  = CH_SP;
		end else begin
			tk.kind = TK_LIT;
			tk.lit  = c;
		end

		p1       = pos_q + adv;
		in_rng1  = p1 < n_q;
		rem1     = n_q - p1;
		w1       = win(hold_q, p1);
		hold1    = in_rng1 && must_hold(w1, rem1, eos_q, bold_nx);
		fin_step = !in_rng1 || hold1;
		// an open bold at end of string needs an extra flush step that emits </b>
		flush_need = fin_step && eos_q && bold_nx;
		tk.last    = fin_step && !flush_need;
		tk.done    = tk.last && eos_q;

		if (flush_q) begin
			tk      = '0;
			tk.kind = TK_BC;
			tk.last = 1'b1;
			tk.done = 1'b1;
		end

		tok_valid = busy_q && (flush_q || !hold0);
		tok       = tk;
		progress  = !tok_valid || !tok_stall;
		fin       = busy_q && progress && (flush_q || hold0 || (fin_step && !flush_need));

		// lookahead left behind for the next transaction
		base_buf = hold_q;
		base_n   = n_q;
		if (busy_q) begin
			if (flush_q) begin
				base_n = 3'd0;
			end else if (hold0) begin
				base_buf = w0;
				base_n   = rem0;
			end else if (hold1) begin
				base_buf = w1;
				base_n   = rem1;
			end else begin
				base_n = 3'd0;
			end
		end

		in_stall = busy_q && !fin;
		in_acc   = in_valid && !in_stall;
		next_buf = base_buf;
		next_buf[base_n] = in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			flush_q <= 1'b0;
			bold_q  <= 1'b0;
			eos_q   <= 1'b0;
			n_q     <= 3'd0;
			pos_q   <= 3'd0;
		end else begin
			if (busy_q && progress) begin
				if (flush_q)
					bold_q <= 1'b0;
				else if (!hold0)
					bold_q <= bold_nx;
			end
			if (in_acc) begin
				busy_q  <= 1'b1;
				flush_q <= 1'b0;
				n_q     <= base_n + 3'd1;
				pos_q   <= 3'd0;
				eos_q   <= end_of_string;
			end else if (fin) begin
				busy_q  <= 1'b0;
				flush_q <= 1'b0;
				n_q     <= base_n;
			end else if (busy_q && progress && !flush_q) begin
				if (flush_need)
					flush_q <= 1'b1;
				else
					pos_q <= p1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			hold_q <= next_buf;
		else if (fin)
			hold_q <= base_buf;
	end

endmodule

`default_nettype wire

// File: rtl/core/she_tokq.sv
// Token queue between front and back end, four entries in flip-flops.
// Depends on she_pkg.
`default_nettype none

module she_tokq
	import she_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_stall,
	input  wire tok_t push_tok,
	output logic      head_valid,
	output tok_t      head_tok,
	input  wire logic pop
);

	tok_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign push_stall = cnt_q == (QAW+1)'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_tok   = mem_q[rd_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_tok;
	end

endmodule

`default_nettype wire

// File: rtl/core/she_back.sv
// Back end: expands tokens into output bytes in the output register, one per
// cycle while out_stall is low. Depends on she_pkg.
`default_nettype none

module she_back
	import she_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire tok_t head_tok,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] out_byte,
	output logic      run_last,
	output logic      string_done
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q, done_q;
	logic [7:0] ch;
	logic       end_tok, load;

	assign ch      = (head_tok.kind == TK_LIT) ? head_tok.lit : str_char(head_tok.kind, idx_q);
	assign end_tok = idx_q == str_len(head_tok.kind) - 3'd1;
	assign load    = head_valid && (!valid_q || !out_stall);
	assign pop     = load && end_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (load)
				idx_q <= end_tok ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= ch;
			last_q <= head_tok.last && end_tok;
			done_q <= head_tok.done && end_tok;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign run_last    = last_q;
	assign string_done = done_q;

endmodule

`default_nettype wire

// File: rtl/core/snippet_html_escaper.sv
// Snippet HTML escaper: input byte stream in, escaped byte stream out.
// Top level; instantiates she_front, she_tokq and she_back. Depends on she_pkg.
//
// Input channel (in_valid / in_stall): one byte per transaction, end_of_string
// set on the last byte of a string. Output channel (out_valid / out_stall):
// one escaped byte per transaction; run_last marks the last byte caused by an
// input transaction, string_done the last byte of the whole string.
// Entities, tag whitelist and bold closing follow the escaping rules; a '<'
// and up to three bytes after it, or a trailing '&', are held back until the
// next byte decides them, so some transactions yield no output at once.
// A byte passes the front-end hold register, a token queue entry and the output
// register on its way out. The front end decides one token per cycle while the
// queue takes it, and takes a new byte in the cycle its previous byte finishes;
// released lookahead yields its tokens before a new byte is taken. The back end
// emits one byte per cycle while out_stall is low, so an entity takes one output
// slot per byte (up to six) and output bandwidth sets the sustained rate. A
// four-entry token queue sits between the two. A stalled receiver holds the
// output register; the queue then fills and in_stall rises. Reset clears bold
// state, held bytes and the queue; no clearing pass is needed.
`default_nettype none

module snippet_html_escaper
	import she_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_string,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            string_done
);

	logic tok_valid, tok_stall, head_valid, pop;
	tok_t tok, head_tok;

	she_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.tok_valid     (tok_valid),
		.tok           (tok),
		.tok_stall     (tok_stall)
	);

	she_tokq u_tokq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (tok_valid),
		.push_stall (tok_stall),
		.push_tok   (tok),
		.head_valid (head_valid),
		.head_tok   (head_tok),
		.pop        (pop)
	);

	she_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_tok    (head_tok),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_done (string_done)
	);

endmodule

`default_nettype wire
